// ===== rtl/core/rvx_pkg.sv =====
// Shared types, codes and defaults for the register VM instruction executor.
`default_nettype none
package rvx_pkg;

  localparam int REG_COUNT_DEF  = 256;
  localparam int HEAP_BYTES_DEF = 65536;
  localparam int CODE_WORDS_DEF = 65536;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_HALT     = 4'd1,
    ST_BAD_OP   = 4'd2,
    ST_BAD_PC   = 4'd3,
    ST_BAD_ADDR = 4'd4,
    ST_BAD_SYS  = 4'd5,
    ST_SYS_REQ  = 4'd6,
    ST_DIV0     = 4'd7,
    ST_IDLE     = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    CMD_EXEC  = 3'd0,
    CMD_HWR   = 3'd1,
    CMD_HRD   = 3'd2,
    CMD_RWR   = 3'd3,
    CMD_START = 3'd4
  } cmd_t;

  typedef enum logic [7:0] {
    OP_HALT = 8'd0,  OP_MOVI = 8'd1,  OP_MOV = 8'd2,   OP_ADD = 8'd3,
    OP_SUB = 8'd4,   OP_MUL = 8'd5,   OP_LDW = 8'd6,   OP_STW = 8'd7,
    OP_JMP = 8'd8,   OP_BEQ = 8'd9,   OP_BNE = 8'd10,  OP_SYSCALL = 8'd11,
    OP_CEQ = 8'd12,  OP_CNE = 8'd13,  OP_CLT = 8'd14,  OP_CLE = 8'd15,
    OP_CLTU = 8'd16, OP_CLEU = 8'd17, OP_DIV = 8'd18,  OP_DIVU = 8'd19,
    OP_MOD = 8'd20,  OP_MODU = 8'd21, OP_SHL = 8'd22,  OP_SHR = 8'd23,
    OP_SAR = 8'd24,  OP_AND = 8'd25,  OP_OR = 8'd26,   OP_XOR = 8'd27
  } op_t;

  typedef enum logic [1:0] {
    CFG_CODE_WORDS = 2'd0,
    CFG_ENTRY      = 2'd1,
    CFG_HEAP_BYTES = 2'd2,
    CFG_SYSCALLS   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WB,
    S_LD,
    S_LDW,
    S_ST,
    S_DIV,
    S_DIVF
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/register_vm_instruction_executor_top.sv =====
// Top level of the register VM instruction executor.
//
//  channel  ports                                   handshake
//  input    in_command .. in_write_value            start && !busy
//  result   out_status .. out_syscall_id            out_valid, one cycle
//  config   cfg_index, cfg_data                     cfg_valid && cfg_ready
//
// One item at a time. Register reads go out in the accept cycle; an item then
// passes S_EXEC alone (branches, syscall, register write, start, faults), S_EXEC
// and S_WB (ALU ops), S_EXEC and an S_LD/S_LDW pair per heap byte (LDW, heap byte
// read), S_EXEC and S_ST per byte (STW, heap byte write) or S_EXEC, S_DIV and S_DIVF
// (divide, one quotient bit per cycle), and the result strobe follows in the idle cycle.
// Reset is synchronous; it clears the register file valid bits, pc and the run
// flag. The heap is not cleared. The receiver cannot stall results.
`default_nettype none
module register_vm_instruction_executor_top #(
  parameter int REG_COUNT  = rvx_pkg::REG_COUNT_DEF,
  parameter int HEAP_BYTES = rvx_pkg::HEAP_BYTES_DEF,
  parameter int CODE_WORDS = rvx_pkg::CODE_WORDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_command,
  input  wire logic [31:0]        in_instruction,
  input  wire logic [15:0]        in_heap_address,
  input  wire logic [7:0]         in_reg_index,
  input  wire logic signed [31:0] in_write_value,
  output logic                    out_valid,
  output logic [3:0]              out_status,
  output logic [31:0]             out_next_pc,
  output logic signed [31:0]      out_result_value,
  output logic [15:0]             out_syscall_id,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [16:0]        cfg_data
);
  import rvx_pkg::*;

  localparam int RI_W = $clog2(REG_COUNT);
  localparam int HA_W = $clog2(HEAP_BYTES);
  localparam logic [31:0] CODE_LIM_MAX = 32'(CODE_WORDS);
  localparam logic [31:0] HEAP_LIM_MAX = 32'(HEAP_BYTES);
  localparam logic [8:0]  REG_LIM      = 9'(REG_COUNT);

  // Configuration.
  logic [16:0] cfg_code_words_r, cfg_heap_bytes_r;
  logic [15:0] cfg_entry_r, cfg_syscalls_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_code_words_r <= 17'd1;
      cfg_entry_r      <= '0;
      cfg_heap_bytes_r <= '0;
      cfg_syscalls_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CODE_WORDS: cfg_code_words_r <= cfg_data;
        CFG_ENTRY:      cfg_entry_r      <= cfg_data[15:0];
        CFG_HEAP_BYTES: cfg_heap_bytes_r <= cfg_data;
        CFG_SYSCALLS:   cfg_syscalls_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [31:0] code_lim, heap_lim, cw32, hb32;
  assign cw32     = {15'd0, cfg_code_words_r};
  assign hb32     = {15'd0, cfg_heap_bytes_r};
  assign code_lim = (cw32 < CODE_LIM_MAX) ? cw32 : CODE_LIM_MAX;
  assign heap_lim = (hb32 < HEAP_LIM_MAX) ? hb32 : HEAP_LIM_MAX;

  // Control and datapath registers.
  state_t      state_r, state_nxt;
  logic        running_r, running_nxt;
  logic [31:0] pc_r, pc_nxt;
  cmd_t        cmd_r;
  logic [31:0] inst_r;
  logic [15:0] haddr_r;
  logic [7:0]  ridx_r;
  logic [31:0] wval_r;
  logic [31:0] res_r, res_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] store_r, store_nxt;
  logic [31:0] word_r, word_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        byte_r, byte_nxt;
  logic [31:0] quo_r, quo_nxt, rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic        negq_r, negq_nxt, negr_r, negr_nxt, wrem_r, wrem_nxt;
  logic        out_valid_r;
  status_t     out_status_r;
  logic [31:0] out_pc_r, out_val_r;
  logic [15:0] out_sid_r;

  // Finish of an item.
  logic        fin;
  status_t     fin_status;
  logic [31:0] fin_val;
  logic [15:0] fin_sid;

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_next_pc      = out_pc_r;
  assign out_result_value = out_val_r;
  assign out_syscall_id   = out_sid_r;

  logic accept;
  assign accept = start && !busy;

  // Register file: two read ports, one write port, valid bit per entry.
  logic [REG_COUNT-1:0] valid_r;
  logic [31:0]          regmem [REG_COUNT];
  logic [7:0]           raddr0, raddr1;
  logic [31:0]          rdat0_r, rdat1_r;
  logic                 rv0_r, rv1_r;
  logic                 wr_en;
  logic [7:0]           wr_idx;
  logic [31:0]          wr_data;
  logic                 wr_ok;

  assign wr_ok = ({1'b0, wr_idx} < REG_LIM);

  always_comb begin
    op_t aop;
    aop = op_t'(in_instruction[7:0]);
    if (aop == OP_HALT || aop == OP_BEQ || aop == OP_BNE) begin
      raddr0 = in_instruction[15:8];
    end else begin
      raddr0 = in_instruction[23:16];
    end
    if (aop == OP_BEQ || aop == OP_BNE) begin
      raddr1 = in_instruction[23:16];
    end else begin
      raddr1 = in_instruction[31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      regmem[wr_idx[RI_W-1:0]] <= wr_data;
    end
    rdat0_r <= regmem[raddr0[RI_W-1:0]];
    rdat1_r <= regmem[raddr1[RI_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rv0_r   <= 1'b0;
      rv1_r   <= 1'b0;
    end else begin
      if (wr_en && wr_ok) begin
        valid_r[wr_idx[RI_W-1:0]] <= 1'b1;
      end
      rv0_r <= valid_r[raddr0[RI_W-1:0]] && ({1'b0, raddr0} < REG_LIM);
      rv1_r <= valid_r[raddr1[RI_W-1:0]] && ({1'b0, raddr1} < REG_LIM);
    end
  end

  logic [31:0] rval0, rval1;
  assign rval0 = rv0_r ? rdat0_r : 32'd0;
  assign rval1 = rv1_r ? rdat1_r : 32'd0;

  // Heap: one byte port, registered read.
  logic [7:0]  heap [HEAP_BYTES];
  logic [31:0] hp_sum;
  logic [HA_W-1:0] hp_idx;
  logic        hp_we;
  logic [7:0]  hp_wdata, hp_rdata_r;
  logic [31:0] store_sh;

  assign hp_sum   = base_r + {30'd0, cnt_r[1:0]};
  assign hp_idx   = hp_sum[HA_W-1:0];
  assign store_sh = store_r >> {cnt_r[1:0], 3'b000};
  assign hp_wdata = byte_r ? store_r[7:0] : store_sh[7:0];

  always_ff @(posedge clk) begin
    if (hp_we) begin
      heap[hp_idx] <= hp_wdata;
    end
    hp_rdata_r <= heap[hp_idx];
  end

  // Decode of the captured word.
  op_t         op;
  logic [7:0]  fa, fc;
  logic [15:0] imm16;
  logic [31:0] pc1, ra, rb, rc, mb, mc;
  logic        signed_div, word_ok;
  logic [32:0] trial;

  assign op    = op_t'(inst_r[7:0]);
  assign fa    = inst_r[15:8];
  assign fc    = inst_r[31:24];
  assign imm16 = inst_r[31:16];
  assign pc1   = pc_r + 32'd1;
  assign ra    = rval0;
  assign rb    = (op == OP_BEQ || op == OP_BNE) ? rval1 : rval0;
  assign rc    = rval1;
  assign signed_div = (op == OP_DIV || op == OP_MOD);
  assign mb    = (signed_div && rb[31]) ? (32'd0 - rb) : rb;
  assign mc    = (signed_div && rc[31]) ? (32'd0 - rc) : rc;
  assign word_ok = !(rb > heap_lim || (heap_lim - rb) < 32'd4);
  assign trial = {rem_r, quo_r[31]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      running_r   <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= cmd_t'(in_command);
      inst_r  <= in_instruction;
      haddr_r <= in_heap_address;
      ridx_r  <= in_reg_index;
      wval_r  <= in_write_value;
    end
    res_r   <= res_nxt;
    base_r  <= base_nxt;
    store_r <= store_nxt;
    word_r  <= word_nxt;
    cnt_r   <= cnt_nxt;
    byte_r  <= byte_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    negq_r  <= negq_nxt;
    negr_r  <= negr_nxt;
    wrem_r  <= wrem_nxt;
    if (fin) begin
      out_status_r <= fin_status;
      out_pc_r     <= pc_nxt;
      out_val_r    <= fin_val;
      out_sid_r    <= fin_sid;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    running_nxt = running_r;
    pc_nxt      = pc_r;
    res_nxt     = res_r;
    base_nxt    = base_r;
    store_nxt   = store_r;
    word_nxt    = word_r;
    cnt_nxt     = cnt_r;
    byte_nxt    = byte_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    dvs_nxt     = dvs_r;
    negq_nxt    = negq_r;
    negr_nxt    = negr_r;
    wrem_nxt    = wrem_r;
    fin         = 1'b0;
    fin_status  = ST_OK;
    fin_val     = '0;
    fin_sid     = '0;
    wr_en       = 1'b0;
    wr_idx      = fa;
    wr_data     = res_r;
    hp_we       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_IDLE;
        case (cmd_r)
          CMD_EXEC: begin
            if (!running_r) begin
              fin = 1'b1;
              fin_status = ST_IDLE;
            end else if (pc_r >= code_lim) begin
              running_nxt = 1'b0;
              fin = 1'b1;
              fin_status = ST_BAD_PC;
            end else begin
              pc_nxt = pc1;
              state_nxt = S_WB;
              case (op)
                OP_HALT: begin
                  running_nxt = 1'b0;
                  state_nxt = S_IDLE;
                  fin = 1'b1;
                  fin_status = ST_HALT;
                  fin_val = ra;
                end
                OP_MOVI: res_nxt = {{16{imm16[15]}}, imm16};
                OP_MOV:  res_nxt = rb;
                OP_ADD:  res_nxt = rb + rc;
                OP_SUB:  res_nxt = rb - rc;
                OP_MUL:  res_nxt = rb * rc;
                OP_LDW, OP_STW: begin
                  if (!word_ok) begin
                    running_nxt = 1'b0;
                    state_nxt = S_IDLE;
                    fin = 1'b1;
                    fin_status = ST_BAD_ADDR;
                  end else begin
                    base_nxt  = rb;
                    store_nxt = rc;
                    cnt_nxt   = '0;
                    byte_nxt  = 1'b0;
                    state_nxt = (op == OP_LDW) ? S_LD : S_ST;
                  end
                end
                OP_JMP: begin
                  pc_nxt = pc1 + {{8{inst_r[31]}}, inst_r[31:8]};
                  state_nxt = S_IDLE;
                  fin = 1'b1;
                end
                OP_BEQ, OP_BNE: begin
                  if ((op == OP_BEQ) == (ra == rb)) begin
                    pc_nxt = pc1 + {{24{fc[7]}}, fc};
                  end
                  state_nxt = S_IDLE;
                  fin = 1'b1;
                end
                OP_SYSCALL: begin
                  state_nxt = S_IDLE;
                  fin = 1'b1;
                  if (imm16 >= cfg_syscalls_r) begin
                    running_nxt = 1'b0;
                    fin_status = ST_BAD_SYS;
                  end else begin
                    fin_status = ST_SYS_REQ;
                    fin_sid = imm16;
                  end
                end
                OP_CEQ:  res_nxt = {31'd0, rb == rc};
                OP_CNE:  res_nxt = {31'd0, rb != rc};
                OP_CLT:  res_nxt = {31'd0, $signed(rb) < $signed(rc)};
                OP_CLE:  res_nxt = {31'd0, $signed(rb) <= $signed(rc)};
                OP_CLTU: res_nxt = {31'd0, rb < rc};
                OP_CLEU: res_nxt = {31'd0, rb <= rc};
                OP_DIV, OP_DIVU, OP_MOD, OP_MODU: begin
                  if (rc == 32'd0) begin
                    running_nxt = 1'b0;
                    state_nxt = S_IDLE;
                    fin = 1'b1;
                    fin_status = ST_DIV0;
                  end else begin
                    quo_nxt   = mb;
                    rem_nxt   = '0;
                    dvs_nxt   = mc;
                    cnt_nxt   = '0;
                    negq_nxt  = signed_div && (rb[31] ^ rc[31]);
                    negr_nxt  = signed_div && rb[31];
                    wrem_nxt  = (op == OP_MOD || op == OP_MODU);
                    state_nxt = S_DIV;
                  end
                end
                OP_SHL: res_nxt = rb << rc[4:0];
                OP_SHR: res_nxt = rb >> rc[4:0];
                OP_SAR: res_nxt = 32'($signed(rb) >>> rc[4:0]);
                OP_AND: res_nxt = rb & rc;
                OP_OR:  res_nxt = rb | rc;
                OP_XOR: res_nxt = rb ^ rc;
                default: begin
                  running_nxt = 1'b0;
                  state_nxt = S_IDLE;
                  fin = 1'b1;
                  fin_status = ST_BAD_OP;
                end
              endcase
            end
          end
          CMD_HWR, CMD_HRD: begin
            if ({16'd0, haddr_r} < heap_lim) begin
              base_nxt  = {16'd0, haddr_r};
              store_nxt = wval_r;
              cnt_nxt   = '0;
              byte_nxt  = 1'b1;
              state_nxt = (cmd_r == CMD_HWR) ? S_ST : S_LD;
            end else begin
              fin = 1'b1;
              fin_status = ST_BAD_ADDR;
            end
          end
          CMD_RWR: begin
            wr_en   = 1'b1;
            wr_idx  = ridx_r;
            wr_data = wval_r;
            fin = 1'b1;
            fin_status = wr_ok ? ST_OK : ST_BAD_ADDR;
          end
          CMD_START: begin
            pc_nxt = {16'd0, cfg_entry_r};
            fin = 1'b1;
            if ({16'd0, cfg_entry_r} < code_lim) begin
              running_nxt = 1'b1;
            end else begin
              running_nxt = 1'b0;
              fin_status = ST_BAD_PC;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_WB: begin
        wr_en = 1'b1;
        fin = 1'b1;
        state_nxt = S_IDLE;
      end

      // The heap read address is stable here; the byte arrives next cycle.
      S_LD: begin
        state_nxt = S_LDW;
      end

      S_LDW: begin
        word_nxt = {hp_rdata_r, word_r[31:8]};
        cnt_nxt  = cnt_r + 5'd1;
        if (byte_r) begin
          fin = 1'b1;
          fin_val = {24'd0, hp_rdata_r};
          state_nxt = S_IDLE;
        end else if (cnt_r[1:0] == 2'd3) begin
          wr_en   = 1'b1;
          wr_data = word_nxt;
          fin = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_LD;
        end
      end

      S_ST: begin
        hp_we   = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (byte_r || cnt_r[1:0] == 2'd3) begin
          fin = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_DIV: begin
        if (!trial[32]) begin
          rem_nxt = trial[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[30:0], quo_r[31]};
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_DIVF;
        end
      end

      S_DIVF: begin
        wr_en = 1'b1;
        if (wrem_r) begin
          wr_data = negr_r ? (32'd0 - rem_r) : rem_r;
        end else begin
          wr_data = negq_r ? (32'd0 - quo_r) : quo_r;
        end
        fin = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/rvx_checker.sv =====
// Port-level checks for the register VM instruction executor, with its bind.
`default_nettype none
module rvx_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [3:0]  out_status,
  input wire logic [15:0] out_syscall_id
);
  import rvx_pkg::*;

  // Every transfer in raises busy in the cycle after it is accepted.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  // A result is shown only once the block has gone idle again.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // Each item that ends brings exactly one result.
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("item ended without result");

  a_sid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_SYS_REQ) |-> (out_syscall_id == 16'd0))
    else $error("syscall id set without request");

endmodule

bind register_vm_instruction_executor_top rvx_checker u_rvx_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_syscall_id(out_syscall_id)
);
`default_nettype wire
